>>> hw/rtl/lgs_pkg.sv
package lgs_pkg;

    // Largest grid the storage is built for
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    // Configuration registers
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 8'd128;

    // Operation codes of a command item
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        op_t        operation;
        logic [6:0] row;
        logic [6:0] col;
        logic       alive_in;
    } cmd_t;

    typedef struct packed {
        logic       cell_alive;
        logic [3:0] neighbor_count;
        logic       bad_position;
    } rsp_t;

endpackage

>>> hw/rtl/life_grid_generation_step_top.sv
// From IDLE, which alone takes a new item: clear or bad position DONE; write
// WR_MOD, DONE; read and step LOAD_L, LOAD_M, RUN (per column in a step), DONE.
// Throughput is set by the single read port of the column memory: a step
// reads and rewrites one column (all rows in parallel) per cycle.
// Reset: grid_width and grid_height return to 128 and per-column valid flags
// clear, so every cell reads dead right away; no clearing pass is needed.
module life_grid_generation_step_top #(
    parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // Command channel
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  lgs_pkg::cmd_t                   cmd,

    // Result channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output lgs_pkg::rsp_t                   rsp
);

    // Column address, row index and extent widths. Extents also hold the
    // 8-bit register values so that out-of-range sizes can be clamped.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = ($clog2(MAX_WIDTH + 1) > lgs_pkg::CFG_DATA_W) ?
                        $clog2(MAX_WIDTH + 1) : lgs_pkg::CFG_DATA_W;
    localparam int XH = ($clog2(MAX_HEIGHT + 1) > lgs_pkg::CFG_DATA_W) ?
                        $clog2(MAX_HEIGHT + 1) : lgs_pkg::CFG_DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_L,
        S_LOAD_M,
        S_RUN,
        S_WR_MOD,
        S_DONE
    } state_t;

    typedef logic [MAX_HEIGHT-1:0] col_t;

    // ------------------------------------------------------------------
    // Configuration registers and active extent
    // ------------------------------------------------------------------
    logic [lgs_pkg::CFG_DATA_W-1:0] grid_width_reg;
    logic [lgs_pkg::CFG_DATA_W-1:0] grid_height_reg;
    logic [XW-1:0]                  w_ext;
    logic [XH-1:0]                  h_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= lgs_pkg::GRID_SIZE_RESET;
            grid_height_reg <= lgs_pkg::GRID_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lgs_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                lgs_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
            endcase
        end
    end

    // A size of zero acts as one; a size beyond the storage acts as the maximum.
    always_comb
    begin
        if (grid_width_reg == '0)
            w_ext = XW'(1);
        else if (XW'(grid_width_reg) > XW'(MAX_WIDTH))
            w_ext = XW'(MAX_WIDTH);
        else
            w_ext = XW'(grid_width_reg);

        if (grid_height_reg == '0)
            h_ext = XH'(1);
        else if (XH'(grid_height_reg) > XH'(MAX_HEIGHT))
            h_ext = XH'(MAX_HEIGHT);
        else
            h_ext = XH'(grid_height_reg);
    end

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    state_t              state_reg;
    logic                rsp_valid_reg;
    lgs_pkg::rsp_t       rsp_reg;
    logic [MAX_WIDTH-1:0] valid_reg;     // column holds written data

    lgs_pkg::op_t        op_reg;
    logic [CW-1:0]       base_reg;       // column in the center of the window
    logic [RW-1:0]       row_reg;
    logic                alive_reg;
    col_t                left_reg;       // original left column, masked
    col_t                mid_raw_reg;    // original center column, unmasked
    lgs_pkg::rsp_t       res_reg;        // result waiting for the output slot

    // ------------------------------------------------------------------
    // Column memory: one word per column, all rows of that column
    // ------------------------------------------------------------------
    col_t                mem [MAX_WIDTH];
    col_t                rd_data_reg;
    logic                rd_valid_reg;
    logic [CW-1:0]       rd_addr;
    logic                mem_we;
    col_t                wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[base_reg] <= wr_data;
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic                cmd_accept;
    logic [XW-1:0]       col_ext;
    logic [XH-1:0]       row_ext;
    logic                cell_op;
    logic                bad_pos;
    col_t                row_mask;
    col_t                data_eff;
    col_t                data_m;
    col_t                mid_m;
    col_t                right_m;
    logic                right_ok;
    col_t                new_col;
    logic [3:0]          cnt_vec [MAX_HEIGHT];
    col_t                wr_col;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign col_ext = XW'(cmd.col);
    assign row_ext = XH'(cmd.row);
    assign cell_op = (cmd.operation == lgs_pkg::OP_WRITE) ||
                     (cmd.operation == lgs_pkg::OP_READ);
    assign bad_pos = (col_ext >= w_ext) || (row_ext >= h_ext);

    // Rows beyond the active height count dead
    always_comb
    begin
        for (int i = 0; i < MAX_HEIGHT; i++)
            row_mask[i] = (XH'(i) < h_ext);
    end

    // A column never written since reset or clear reads as all dead
    assign data_eff = rd_valid_reg ? rd_data_reg : '0;
    assign data_m   = data_eff & row_mask;
    assign mid_m    = mid_raw_reg & row_mask;
    assign right_ok = (XW'(base_reg) + XW'(1)) < w_ext;
    assign right_m  = right_ok ? data_m : '0;

    // Count neighbors for every row of the center column at once; a shift
    // by one row brings the vertical neighbors in, with dead cells at the ends.
    always_comb
    begin
        col_t l_up, l_dn, m_up, m_dn, r_up, r_dn;
        l_up = left_reg << 1;
        l_dn = left_reg >> 1;
        m_up = mid_m << 1;
        m_dn = mid_m >> 1;
        r_up = right_m << 1;
        r_dn = right_m >> 1;
        for (int i = 0; i < MAX_HEIGHT; i++)
        begin
            cnt_vec[i] = 4'(l_up[i]) + 4'(left_reg[i]) + 4'(l_dn[i]) +
                         4'(m_up[i]) + 4'(m_dn[i]) +
                         4'(r_up[i]) + 4'(right_m[i]) + 4'(r_dn[i]);
            new_col[i] = (cnt_vec[i] == lgs_pkg::BIRTH_COUNT) ||
                         (mid_m[i] && (cnt_vec[i] == lgs_pkg::SURVIVE_COUNT));
        end
    end

    // Single-cell write merges into the stored column
    always_comb
    begin
        wr_col          = data_eff;
        wr_col[row_reg] = alive_reg;
    end

    // Keep stored bits of rows outside the active area during a step
    assign mem_we  = ((state_reg == S_RUN) && (op_reg == lgs_pkg::OP_STEP)) ||
                     (state_reg == S_WR_MOD);
    assign wr_data = (state_reg == S_WR_MOD) ? wr_col :
                     ((new_col & row_mask) | (mid_raw_reg & ~row_mask));

    // Read address: fetch left, center, right, then run one column ahead
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
                rd_addr = (cmd.operation == lgs_pkg::OP_WRITE) ?
                          CW'(col_ext) : CW'(col_ext - XW'(1));
            S_LOAD_L: rd_addr = base_reg;
            S_LOAD_M: rd_addr = base_reg + CW'(1);
            S_RUN:    rd_addr = base_reg + CW'(2);
            default:  rd_addr = base_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: state, column valid flags and the output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
                rsp_valid_reg <= 1'b0;
            if (mem_we)
                valid_reg[base_reg] <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        unique case (cmd.operation)
                            lgs_pkg::OP_WRITE: state_reg <= bad_pos ? S_DONE : S_WR_MOD;
                            lgs_pkg::OP_READ:  state_reg <= bad_pos ? S_DONE : S_LOAD_L;
                            lgs_pkg::OP_STEP:  state_reg <= S_LOAD_L;
                            lgs_pkg::OP_CLEAR:
                            begin
                                // drop every column at once
                                valid_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_LOAD_L: state_reg <= S_LOAD_M;
                S_LOAD_M: state_reg <= S_RUN;
                S_RUN:
                begin
                    if ((op_reg == lgs_pkg::OP_READ) || !right_ok)
                        state_reg <= S_DONE;
                end
                S_WR_MOD: state_reg <= S_DONE;
                S_DONE:
                begin
                    // hold the result until the output slot frees up
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Payload registers of the item in work
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_reg    <= cmd.operation;
                    row_reg   <= RW'(row_ext);
                    alive_reg <= cmd.alive_in;
                    base_reg  <= (cmd.operation == lgs_pkg::OP_STEP) ? '0 : CW'(col_ext);
                    res_reg   <= '{cell_alive: 1'b0, neighbor_count: 4'd0,
                                   bad_position: cell_op && bad_pos};
                end
            end
            S_LOAD_L:
                left_reg <= (base_reg != '0) ? data_m : '0;
            S_LOAD_M:
                mid_raw_reg <= data_eff;
            S_RUN:
            begin
                if (op_reg == lgs_pkg::OP_READ)
                begin
                    res_reg.cell_alive     <= mid_m[row_reg];
                    res_reg.neighbor_count <= cnt_vec[row_reg];
                end
                else
                begin
                    // advance the window by one column
                    left_reg    <= mid_m;
                    mid_raw_reg <= data_eff;
                    base_reg    <= base_reg + CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (XW'(base_reg) < w_ext))
        else $error("step window beyond active width");

    a_clear_drops_all: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd.operation == lgs_pkg::OP_CLEAR)) |=> (valid_reg == '0))
        else $error("clear left a column valid");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.neighbor_count <= 4'd8))
        else $error("neighbor count above eight");

    a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.bad_position) |->
            (!rsp_reg.cell_alive && (rsp_reg.neighbor_count == 4'd0)))
        else $error("flagged position returned cell data");

    a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (XW'(base_reg) < w_ext))
        else $error("memory write outside active width");

endmodule

>>> dv/life_grid_generation_step_checker.sv
`timescale 1ns / 1ps
module life_grid_generation_step_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            cmd_valid,
    input  logic                            cmd_stall,
    input  lgs_pkg::cmd_t                   cmd,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  lgs_pkg::rsp_t                   rsp,
    output int                              outstanding,
    output int                              fail_count
);

    localparam int COLS        = lgs_pkg::MAX_WIDTH_DEF;
    localparam int ROWS        = lgs_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_REPORTS = 10;

    // Column-major copy of the grid; snap is the frozen generation being read
    logic [ROWS-1:0]                cells [COLS];
    logic [ROWS-1:0]                snap  [COLS];
    logic [lgs_pkg::CFG_DATA_W-1:0] width_reg;
    logic [lgs_pkg::CFG_DATA_W-1:0] height_reg;
    int                             act_w;
    int                             act_h;
    lgs_pkg::rsp_t                  results_due [$];
    lgs_pkg::rsp_t                  want;
    int                             n_taken;
    int                             n_returned;

    assign outstanding = n_taken - n_returned;

    // Zero acts as one, anything above the storage acts as the storage size
    function automatic int extent(input logic [lgs_pkg::CFG_DATA_W-1:0] v,
                                  input int top);
        if (v == '0)
            return 1;
        if (int'(v) > top)
            return top;
        return int'(v);
    endfunction

    function automatic logic snap_live(input int r, input int c);
        if (r < 0 || c < 0 || r >= act_h || c >= act_w)
            return 1'b0;
        return snap[c][r];
    endfunction

    function automatic logic [3:0] snap_neighbors(input int r, input int c);
        logic [3:0] n;
        n = '0;
        for (int dc = -1; dc <= 1; dc++)
            for (int dr = -1; dr <= 1; dr++)
                if (dr != 0 || dc != 0)
                    n = n + 4'(snap_live(r + dr, c + dc));
        return n;
    endfunction

    // Update the grid copy for one command and return the result it must produce
    function automatic lgs_pkg::rsp_t apply_command(input lgs_pkg::cmd_t c);
        lgs_pkg::rsp_t res;
        int            r;
        int            k;
        logic [3:0]    n;
        res   = '0;
        act_w = extent(width_reg, COLS);
        act_h = extent(height_reg, ROWS);
        r     = int'(c.row);
        k     = int'(c.col);
        case (c.operation)
            lgs_pkg::OP_WRITE, lgs_pkg::OP_READ:
            begin
                if (r >= act_h || k >= act_w)
                    res.bad_position = 1'b1;
                else if (c.operation == lgs_pkg::OP_WRITE)
                    cells[k][r] = c.alive_in;
                else
                begin
                    snap               = cells;
                    res.cell_alive     = snap_live(r, k);
                    res.neighbor_count = snap_neighbors(r, k);
                end
            end
            lgs_pkg::OP_STEP:
            begin
                // cells beyond the active area keep their bits
                snap = cells;
                for (int cc = 0; cc < act_w; cc++)
                    for (int rr = 0; rr < act_h; rr++)
                    begin
                        n = snap_neighbors(rr, cc);
                        cells[cc][rr] = (n == lgs_pkg::BIRTH_COUNT) ||
                                        (snap[cc][rr] && n == lgs_pkg::SURVIVE_COUNT);
                    end
            end
            default:
            begin
                foreach (cells[i])
                    cells[i] = '0;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (cells[i])
                cells[i] = '0;
            width_reg  = lgs_pkg::GRID_SIZE_RESET;
            height_reg = lgs_pkg::GRID_SIZE_RESET;
            results_due.delete();
            n_taken    <= 0;
            n_returned <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == lgs_pkg::REG_GRID_WIDTH)
                    width_reg = cfg_wdata;
                else if (cfg_index == lgs_pkg::REG_GRID_HEIGHT)
                    height_reg = cfg_wdata;
            end
            if (rsp_valid && !rsp_stall)
            begin
                n_returned <= n_returned + 1;
                if (results_due.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result: alive=%0d count=%0d bad=%0d",
                                 rsp.cell_alive, rsp.neighbor_count, rsp.bad_position);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp.cell_alive !== want.cell_alive ||
                        rsp.neighbor_count !== want.neighbor_count ||
                        rsp.bad_position !== want.bad_position)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("mismatch alive/count/bad: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     want.cell_alive, want.neighbor_count,
                                     want.bad_position, rsp.cell_alive,
                                     rsp.neighbor_count, rsp.bad_position);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                results_due.push_back(apply_command(cmd));
                n_taken <= n_taken + 1;
            end
        end
    end

endmodule

>>> dv/life_grid_generation_step_top_test.sv
`timescale 1ns / 1ps
module life_grid_generation_step_top_test;

    // Longest quiet stretch in a correct run: the long receiver hold-off on top
    // of a full-width step and a long sender gap; allow several times that.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 140;
    localparam int SQUEEZE_CYCLES  = 300;
    localparam int RUN_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int WINDOW          = 6;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           cmd_valid;
    logic                           cmd_stall;
    lgs_pkg::cmd_t                  cmd;
    logic                           rsp_valid;
    logic                           rsp_stall;
    lgs_pkg::rsp_t                  rsp;
    int                             outstanding;
    int                             fail_count;

    // Sizes for the random phases: small areas, the full grid, and
    // out-of-range register values (255 acts as 128, 0 acts as 1)
    logic [lgs_pkg::CFG_DATA_W-1:0] phase_w [RUN_PHASES] =
        '{8'd5, 8'd128, 8'd1, 8'd12, 8'd255, 8'd2};
    logic [lgs_pkg::CFG_DATA_W-1:0] phase_h [RUN_PHASES] =
        '{8'd4, 8'd128, 8'd9, 8'd3, 8'd0, 8'd128};

    bit squeeze_req;
    bit squeeze_done;
    bit no_gaps;
    int area_w;
    int area_h;
    int win_r0;
    int win_c0;
    int win_h;
    int win_w;
    int idle_cycles;

    life_grid_generation_step_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Watch both channels, track the grid and compare every result
    life_grid_generation_step_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic lgs_pkg::cmd_t make_cmd(input lgs_pkg::op_t op, input int r,
                                               input int c, input logic a);
        lgs_pkg::cmd_t t;
        t.operation = op;
        t.row       = 7'(r);
        t.col       = 7'(c);
        t.alive_in  = a;
        return t;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Random command, positions mostly inside a small window so that the
    // pattern is dense enough for births, survivals and high neighbor counts
    function automatic lgs_pkg::cmd_t random_cmd();
        lgs_pkg::cmd_t t;
        int            p;
        t.alive_in = ($urandom_range(0, 99) < 60);
        if ($urandom_range(0, 99) < 15)
        begin
            t.row = 7'($urandom);
            t.col = 7'($urandom);
        end
        else
        begin
            t.row = 7'(win_r0 + $urandom_range(0, win_h - 1));
            t.col = 7'(win_c0 + $urandom_range(0, win_w - 1));
        end
        p = $urandom_range(0, 99);
        if (p < 45)
            t.operation = lgs_pkg::OP_WRITE;
        else if (p < 80)
            t.operation = lgs_pkg::OP_READ;
        else if (p < 95)
            t.operation = lgs_pkg::OP_STEP;
        else
            t.operation = lgs_pkg::OP_CLEAR;
        return t;
    endfunction

    // Offer one item, hold it until accepted, then maybe idle for a while
    task automatic issue(input lgs_pkg::cmd_t c);
        int gap;
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain the block, then write both size registers and pick a new window
    task automatic set_area(input logic [lgs_pkg::CFG_DATA_W-1:0] w,
                            input logic [lgs_pkg::CFG_DATA_W-1:0] h);
        int k;
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= lgs_pkg::REG_GRID_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= lgs_pkg::REG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        area_w = (w == 0) ? 1 :
                 ((int'(w) > lgs_pkg::MAX_WIDTH_DEF) ? lgs_pkg::MAX_WIDTH_DEF : int'(w));
        area_h = (h == 0) ? 1 :
                 ((int'(h) > lgs_pkg::MAX_HEIGHT_DEF) ? lgs_pkg::MAX_HEIGHT_DEF : int'(h));
        win_w  = (area_w < WINDOW) ? area_w : WINDOW;
        win_h  = (area_h < WINDOW) ? area_h : WINDOW;
        // place the window on an edge or corner most of the time
        k = $urandom_range(0, 2);
        win_r0 = (k == 0) ? 0 : ((k == 1) ? area_h - win_h : $urandom_range(0, area_h - win_h));
        k = $urandom_range(0, 2);
        win_c0 = (k == 0) ? 0 : ((k == 1) ? area_w - win_w : $urandom_range(0, area_w - win_w));
    endtask

    // Command side: reset, directed cases, random phases, drain, verdict
    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= lgs_pkg::REG_GRID_WIDTH;
        cfg_wdata <= '0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        no_gaps     = 1'b0;
        squeeze_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full grid after reset: far corner, a blinker in the middle, clear
        issue(make_cmd(lgs_pkg::OP_WRITE, 127, 127, 1'b1));
        issue(make_cmd(lgs_pkg::OP_READ, 127, 127, 1'b0));
        issue(make_cmd(lgs_pkg::OP_WRITE, 64, 63, 1'b1));
        issue(make_cmd(lgs_pkg::OP_WRITE, 64, 64, 1'b1));
        issue(make_cmd(lgs_pkg::OP_WRITE, 64, 65, 1'b1));
        issue(make_cmd(lgs_pkg::OP_READ, 64, 64, 1'b0));
        issue(make_cmd(lgs_pkg::OP_STEP, 0, 0, 1'b0));
        issue(make_cmd(lgs_pkg::OP_READ, 63, 64, 1'b0));
        issue(make_cmd(lgs_pkg::OP_READ, 64, 63, 1'b0));
        issue(make_cmd(lgs_pkg::OP_CLEAR, 127, 127, 1'b1));

        // 3x3 area: ring of eight around a dead center, reads and writes
        // just past the edge, then a step where the center is not born
        set_area(8'd3, 8'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (r != 1 || c != 1)
                    issue(make_cmd(lgs_pkg::OP_WRITE, r, c, 1'b1));
        issue(make_cmd(lgs_pkg::OP_READ, 1, 1, 1'b0));
        issue(make_cmd(lgs_pkg::OP_WRITE, 1, 3, 1'b1));
        issue(make_cmd(lgs_pkg::OP_READ, 3, 0, 1'b0));
        issue(make_cmd(lgs_pkg::OP_STEP, 0, 0, 1'b0));

        // Zero width acts as one column, 255 rows as 128; a step here must
        // leave the hidden columns of the 3x3 pattern alone
        set_area(8'd0, 8'd255);
        issue(make_cmd(lgs_pkg::OP_READ, 127, 0, 1'b0));
        issue(make_cmd(lgs_pkg::OP_WRITE, 0, 1, 1'b0));
        issue(make_cmd(lgs_pkg::OP_STEP, 0, 0, 1'b0));

        // 255 columns and zero rows: one full-width row
        set_area(8'd255, 8'd0);
        issue(make_cmd(lgs_pkg::OP_READ, 0, 127, 1'b0));

        // Random phases; the second one runs back to back under the long
        // receiver hold-off so the block fills and stalls its input
        for (int p = 0; p < RUN_PHASES; p++)
        begin
            set_area(phase_w[p], phase_h[p]);
            no_gaps = (p == 1) || (p == 4);
            if (p == 1)
                squeeze_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                issue(random_cmd());
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random stall runs, some long free-running stretches,
    // and one long hold-off as soon as it is asked for
    initial
    begin
        int p;
        int run_len;
        logic hold;
        rsp_stall <= 1'b0;
        squeeze_done = 1'b0;
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                rsp_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 15)
                begin
                    hold    = 1'b0;
                    run_len = $urandom_range(40, 100);
                end
                else if (p < 65)
                begin
                    hold    = 1'b0;
                    run_len = $urandom_range(1, 6);
                end
                else if (p < 92)
                begin
                    hold    = 1'b1;
                    run_len = $urandom_range(1, 3);
                end
                else
                begin
                    hold    = 1'b1;
                    run_len = $urandom_range(12, 40);
                end
                rsp_stall <= hold;
                for (int k = 0; k < run_len; k++)
                begin
                    if (squeeze_req && !squeeze_done)
                        break;
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel nor the config port moves
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
